/* sv/constrained_lms_beamformer_top_defines.svh */
`ifndef CONSTRAINED_LMS_BEAMFORMER_TOP_DEFINES_SVH
`define CONSTRAINED_LMS_BEAMFORMER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CLMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CLMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/clms_pkg.sv */
`timescale 1ns / 1ps

package clms_pkg;

  localparam int CHANNELS  = 4;
  localparam int TAP_COUNT = 64;

  localparam int AW      = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CH_LOG2 = $clog2(CHANNELS);
  localparam int CIW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW      = $clog2(CHANNELS + 1);
  localparam int ACC_W   = 48 + $clog2(CHANNELS * TAP_COUNT) + 1;

  localparam logic [47:0] STEP_RESET = 48'd5629;

  // one weight row: all channel weights of a tap plus its desired value
  typedef struct packed {
    logic [CHANNELS-1:0][31:0] w;
    logic [31:0]               d;
  } wrow_t;

  // one delay row: noisy and clean samples of every channel at one position
  typedef struct packed {
    logic [CHANNELS-1:0][15:0] noisy;
    logic [CHANNELS-1:0][15:0] clean;
  } srow_t;

  // divide by the channel count, truncated toward zero (power-of-two count)
  function automatic logic signed [63:0] div_ch(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + ((v < 0) ? 64'(CHANNELS - 1) : 64'sd0);
    return b >>> CH_LOG2;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

endpackage

/* sv/clms_ram.sv */
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module clms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/constrained_lms_beamformer_top.sv */
`timescale 1ns / 1ps

// Frost-type constrained LMS beamformer. A load word (operation 0) stores
// desired_value/CHANNELS as one desired tap and sets that tap of every
// channel's weights to it; it answers with an all-zero result word. A
// sample word (operation 1) runs four passes over a weight
// RAM (one row per tap) and a circular delay-line RAM: filter on noisy data,
// weight update (read-modify-write of each row), insertion of the new
// samples, filter on clean data. One weight*sample product is formed per
// cycle during the filter passes. One word is worked at a time; the
// finished result sits in an output register, so the next word is
// accepted while it waits. After reset a clearing pass over every RAM
// row zeroes both RAMs with in_stall high. step_size is written through
// cfg_wr_en/cfg_step_size; the user must write it only while idle, as
// the block itself does not enforce this.
module constrained_lms_beamformer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [47:0]        cfg_step_size,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [5:0]         in_tap_index,
  input  logic signed [31:0] in_desired_value,
  input  logic signed [15:0] in_mic_sample_0,
  input  logic signed [15:0] in_mic_sample_1,
  input  logic signed [15:0] in_mic_sample_2,
  input  logic signed [15:0] in_mic_sample_3,
  input  logic signed [15:0] in_noise_sample_0,
  input  logic signed [15:0] in_noise_sample_1,
  input  logic signed [15:0] in_noise_sample_2,
  input  logic signed [15:0] in_noise_sample_3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_adapt_output,
  output logic signed [31:0] out_clean_output
);

  localparam int CH  = clms_pkg::CHANNELS;
  localparam int TC  = clms_pkg::TAP_COUNT;
  localparam int AW  = clms_pkg::AW;
  localparam int CW  = clms_pkg::CW;
  localparam int CIW = clms_pkg::CIW;
  localparam int AC  = clms_pkg::ACC_W;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD,
    S_A_RD, S_A_MAC, S_A_END, S_A_Y,
    S_MU1, S_MU2, S_MU3,
    S_B_RD, S_B_MEAN, S_B_MUL, S_B_WR,
    S_SHIFT,
    S_C_RD, S_C_MAC, S_C_END, S_C_Z,
    S_DONE
  } state_t;

  state_t state_r;

  logic [AW-1:0]          t_r, h_r, tap_r;
  logic [CW-1:0]          cnt_r;
  logic                   tap_ok_r;
  logic signed [31:0]     dval_r;
  clms_pkg::srow_t        new_row_r;
  logic [47:0]            step_r;
  logic signed [AC-1:0]   acc_r;
  logic signed [47:0]     prod_r;
  logic                   prod_v_r;
  logic signed [31:0]     y_r, z_r;
  logic signed [34:0]     phi_r;
  logic signed [48:0]     plo_r;
  logic signed [39:0]     muy_r;
  clms_pkg::wrow_t        row_r;
  logic [CH-1:0][15:0]    nz_r;
  logic signed [34:0]     corr_r;
  logic signed [17:0]     xmean_r;
  logic signed [57:0]     pb_r;
  logic                   out_valid_r;
  logic signed [31:0]     out_adapt_r, out_clean_r;

  // RAM ports
  logic                   w_we, s_we, rd_en;
  logic [AW-1:0]          w_waddr, s_waddr, rd_t, s_raddr;
  clms_pkg::wrow_t        w_wdata, w_rdata;
  clms_pkg::srow_t        s_wdata, s_rdata;

  logic                   t_last;
  logic [AW-1:0]          h_new;
  logic [AW:0]            phys_sum;
  logic [CIW-1:0]         cidx, jidx;

  logic signed [15:0]     mic_a [4];
  logic signed [15:0]     noise_a [4];

  assign mic_a   = '{in_mic_sample_0, in_mic_sample_1, in_mic_sample_2, in_mic_sample_3};
  assign noise_a = '{in_noise_sample_0, in_noise_sample_1, in_noise_sample_2,
                     in_noise_sample_3};

  assign t_last = (t_r == AW'(TC - 1));
  assign h_new  = (h_r == '0) ? AW'(TC - 1) : h_r - AW'(1);
  assign cidx   = cnt_r[CIW-1:0];
  assign jidx   = CIW'(cnt_r - CW'(1));

  // read address: delay index rd_t lives at (h + rd_t) mod TAP_COUNT
  always_comb begin
    rd_en = 1'b0;
    rd_t  = t_r;
    case (state_r)
      S_A_RD, S_B_RD, S_C_RD: begin
        rd_en = 1'b1;
        rd_t  = '0;
      end
      S_A_MAC, S_C_MAC: begin
        if (cnt_r == CW'(CH - 1) && !t_last) begin
          rd_en = 1'b1;
          rd_t  = t_r + AW'(1);
        end
      end
      S_B_WR: begin
        if (!t_last) begin
          rd_en = 1'b1;
          rd_t  = t_r + AW'(1);
        end
      end
      default: ;
    endcase
    phys_sum = {1'b0, h_r} + {1'b0, rd_t};
    if (phys_sum >= (AW+1)'(TC)) phys_sum = phys_sum - (AW+1)'(TC);
    s_raddr = phys_sum[AW-1:0];
  end

  // write ports
  always_comb begin
    w_we    = 1'b0;
    w_waddr = t_r;
    w_wdata = row_r;
    s_we    = 1'b0;
    s_waddr = t_r;
    s_wdata = new_row_r;
    case (state_r)
      S_CLR: begin
        w_we    = 1'b1;
        w_wdata = '0;
        s_we    = 1'b1;
        s_wdata = '0;
      end
      S_LOAD: begin
        w_we    = tap_ok_r;
        w_waddr = tap_r;
        for (int c = 0; c < CH; c++) w_wdata.w[c] = dval_r;
        w_wdata.d = dval_r;
      end
      S_B_WR: w_we = 1'b1;
      S_SHIFT: begin
        s_we    = 1'b1;
        s_waddr = h_new;
      end
      default: ;
    endcase
  end

  clms_ram #(.WIDTH($bits(clms_pkg::wrow_t)), .DEPTH(TC)) u_wram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(rd_en), .raddr(rd_t), .rdata(w_rdata)
  );

  clms_ram #(.WIDTH($bits(clms_pkg::srow_t)), .DEPTH(TC)) u_sram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(rd_en), .raddr(s_raddr), .rdata(s_rdata)
  );

  // sequencer and datapath
  always_ff @(posedge clk) begin
    logic signed [63:0] ws, xs, s64;
    logic signed [56:0] p57;
    logic signed [17:0] diff;
    logic signed [15:0] xsel;
    ws   = '0;
    xs   = '0;
    s64  = '0;
    p57  = '0;
    diff = '0;
    xsel = '0;
    if (!rst_n) begin
      state_r     <= S_CLR;
      t_r         <= '0;
      h_r         <= '0;
      cnt_r       <= '0;
      step_r      <= clms_pkg::STEP_RESET;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) step_r <= cfg_step_size;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // MAC accumulator adds the registered product in the cycle after it is formed
      if (prod_v_r) acc_r <= acc_r + AC'(prod_r);
      prod_v_r <= 1'b0;

      case (state_r)
        S_CLR: begin
          t_r <= t_r + AW'(1);
          if (t_last) begin
            t_r     <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            tap_ok_r <= (32'(in_tap_index) < 32'(TC));
            tap_r    <= AW'(in_tap_index);
            dval_r   <= 32'(clms_pkg::div_ch(64'(in_desired_value)));
            for (int c = 0; c < CH; c++) begin
              new_row_r.clean[c] <= mic_a[c];
              new_row_r.noisy[c] <= clms_pkg::sat16(18'(mic_a[c]) + 18'(noise_a[c]));
            end
            y_r      <= '0;
            z_r      <= '0;
            acc_r    <= '0;
            t_r      <= '0;
            cnt_r    <= '0;
            state_r  <= in_operation ? S_A_RD : S_LOAD;
          end
        end
        S_LOAD: state_r <= S_DONE;
        S_A_RD, S_C_RD: begin
          t_r     <= '0;
          cnt_r   <= '0;
          state_r <= (state_r == S_A_RD) ? S_A_MAC : S_C_MAC;
        end
        S_A_MAC, S_C_MAC: begin
          xsel = (state_r == S_C_MAC) ? $signed(s_rdata.clean[cidx])
                                      : $signed(s_rdata.noisy[cidx]);
          prod_r   <= xsel * $signed(w_rdata.w[cidx]);
          prod_v_r <= 1'b1;
          cnt_r    <= cnt_r + CW'(1);
          if (cnt_r == CW'(CH - 1)) begin
            cnt_r <= '0;
            t_r   <= t_r + AW'(1);
            if (t_last) state_r <= (state_r == S_A_MAC) ? S_A_END : S_C_END;
          end
        end
        S_A_END: state_r <= S_A_Y;
        S_C_END: state_r <= S_C_Z;
        S_A_Y: begin
          y_r     <= clms_pkg::sat32(64'(acc_r) >>> 28);
          state_r <= S_MU1;
        end
        S_MU1: begin
          p57 = y_r * $signed({1'b0, step_r[47:24]});
          if (64'(p57) > 64'sd8589934592) phi_r <= 35'sd8589934592;
          else if (64'(p57) < -64'sd8589934592) phi_r <= -35'sd8589934592;
          else phi_r <= 35'(p57);
          state_r <= S_MU2;
        end
        S_MU2: begin
          p57 = y_r * $signed({1'b0, step_r[23:0]});
          plo_r   <= 49'(p57 >>> 8);
          state_r <= S_MU3;
        end
        S_MU3: begin
          s64 = (64'(phi_r) <<< 16) + 64'(plo_r);
          if (s64 > 64'sd549755813887) muy_r <= 40'sh7fffffffff;
          else if (s64 < -64'sd549755813888) muy_r <= 40'sh8000000000;
          else muy_r <= 40'(s64);
          state_r <= S_B_RD;
        end
        S_B_RD: begin
          t_r     <= '0;
          state_r <= S_B_MEAN;
        end
        S_B_MEAN: begin
          for (int c = 0; c < CH; c++) begin
            ws = ws + 64'($signed(w_rdata.w[c]));
            xs = xs + 64'($signed(s_rdata.noisy[c]));
          end
          corr_r  <= 35'(clms_pkg::div_ch(ws) - 64'($signed(w_rdata.d)));
          xmean_r <= 18'(clms_pkg::div_ch(xs));
          row_r   <= w_rdata;
          nz_r    <= s_rdata.noisy;
          cnt_r   <= '0;
          state_r <= S_B_MUL;
        end
        S_B_MUL: begin
          // product for channel cnt, write-back for channel cnt-1
          if (cnt_r < CW'(CH)) begin
            diff = xmean_r - 18'($signed(nz_r[cidx]));
            pb_r <= muy_r * diff;
          end
          if (cnt_r != '0) begin
            s64 = 64'($signed(row_r.w[jidx])) + 64'(pb_r >>> 12) - 64'(corr_r);
            row_r.w[jidx] <= clms_pkg::sat32(s64);
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(CH)) state_r <= S_B_WR;
        end
        S_B_WR: begin
          t_r <= t_r + AW'(1);
          if (t_last) state_r <= S_SHIFT;
          else state_r <= S_B_MEAN;
        end
        S_SHIFT: begin
          h_r     <= h_new;
          acc_r   <= '0;
          state_r <= S_C_RD;
        end
        S_C_Z: begin
          z_r     <= clms_pkg::sat32(64'(acc_r) >>> 28);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_adapt_r <= y_r;
            out_clean_r <= z_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_adapt_output = out_adapt_r;
  assign out_clean_output = out_clean_r;

endmodule

/* sv/clms_checker.sv */
`timescale 1ns / 1ps
`include "constrained_lms_beamformer_top_defines.svh"

module clms_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_adapt_output,
  input logic signed [31:0] out_clean_output
);

  // a held result word keeps its payload
  `CLMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_adapt_output) && $stable(out_clean_output), "result word changed while stalled")

  // one word at a time: the block is busy right after taking a word
  `CLMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken back to back")

  // no result can appear in the cycle after a word is taken
  `CLMS_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result rose right after accept")

endmodule

bind constrained_lms_beamformer_top clms_checker u_clms_checker (.*);

/* sim/tb_constrained_lms_beamformer_top.sv */
`timescale 1ns / 1ps

module tb_constrained_lms_beamformer_top;

  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles with no word moving
  localparam int LONG_HOLD      = 3000;   // receiver hold-off for the fill-up test
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct {
    logic               op;
    logic [5:0]         tap;
    logic signed [31:0] desired;
    logic signed [15:0] mic [clms_pkg::CHANNELS];
    logic signed [15:0] noise [clms_pkg::CHANNELS];
  } beam_word_t;

  typedef struct {
    logic signed [31:0] adapt;
    logic signed [31:0] clean;
  } beam_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [47:0] cfg_step_size = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [5:0] in_tap_index = '0;
  logic signed [31:0] in_desired_value = '0;
  logic signed [15:0] in_mic [clms_pkg::CHANNELS];
  logic signed [15:0] in_noise [clms_pkg::CHANNELS];
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_adapt_output, out_clean_output;

  initial begin
    for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
      in_mic[c] = '0;
      in_noise[c] = '0;
    end
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  constrained_lms_beamformer_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_step_size(cfg_step_size),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_tap_index(in_tap_index),
    .in_desired_value(in_desired_value),
    .in_mic_sample_0(in_mic[0]), .in_mic_sample_1(in_mic[1]),
    .in_mic_sample_2(in_mic[2]), .in_mic_sample_3(in_mic[3]),
    .in_noise_sample_0(in_noise[0]), .in_noise_sample_1(in_noise[1]),
    .in_noise_sample_2(in_noise[2]), .in_noise_sample_3(in_noise[3]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_adapt_output(out_adapt_output), .out_clean_output(out_clean_output)
  );

  // ---------------------------------------------------------------------
  // Beamformer model: own copy of the step, weights and delay lines
  // ---------------------------------------------------------------------
  logic [47:0]        mdl_step;
  logic signed [31:0] mdl_w [clms_pkg::CHANNELS][clms_pkg::TAP_COUNT];
  logic signed [15:0] mdl_noisy [clms_pkg::CHANNELS][clms_pkg::TAP_COUNT];
  logic signed [15:0] mdl_clean [clms_pkg::CHANNELS][clms_pkg::TAP_COUNT];
  logic signed [31:0] mdl_desired [clms_pkg::TAP_COUNT];

  beam_result_t pending_results [$];
  int  fail_count = 0;
  bit  sender_gaps = 1'b1;     // random idling on the input side
  bit  receiver_gaps = 1'b1;   // random stall bursts on the output side
  bit  hold_request = 1'b0;    // ask the receiver for one long hold-off

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact Q.28 sum, floored (>>> on signed is floor), then saturated.
  function automatic longint array_output(bit use_clean);
    longint acc;
    acc = 0;
    for (int c = 0; c < clms_pkg::CHANNELS; c++)
      for (int t = 0; t < clms_pkg::TAP_COUNT; t++)
        acc += longint'(use_clean ? mdl_clean[c][t] : mdl_noisy[c][t]) *
               longint'(mdl_w[c][t]);
    return clip(acc >>> 28, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void model_reset();
    mdl_step = clms_pkg::STEP_RESET;
    for (int t = 0; t < clms_pkg::TAP_COUNT; t++) begin
      mdl_desired[t] = '0;
      for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
        mdl_w[c][t] = '0;
        mdl_noisy[c][t] = '0;
        mdl_clean[c][t] = '0;
      end
    end
  endfunction

  function automatic beam_result_t beamform(beam_word_t wd);
    beam_result_t r;
    longint y, z, mu_hi, mu_lo, p_hi, mu_y, ws, xs, corr, xmean, delta, nw, m, n;
    r.adapt = '0;
    r.clean = '0;
    if (wd.op == OP_LOAD) begin
      // tap_index is 6 bits and TAP_COUNT is 64, so every load lands
      mdl_desired[wd.tap] = 32'(longint'(wd.desired) / clms_pkg::CHANNELS);
      for (int c = 0; c < clms_pkg::CHANNELS; c++) mdl_w[c][wd.tap] = mdl_desired[wd.tap];
      return r;
    end
    y = array_output(1'b0);
    // mu*y split in two halves so the product never overflows
    mu_hi = longint'(mdl_step >> 24);
    mu_lo = longint'(mdl_step[23:0]);
    p_hi  = clip(y * mu_hi, -(64'sd1 << 33), 64'sd1 << 33);
    mu_y  = p_hi * 65536 + ((y * mu_lo) >>> 8);
    mu_y  = clip(mu_y, -(64'sd1 << 39), (64'sd1 << 39) - 1);
    for (int t = 0; t < clms_pkg::TAP_COUNT; t++) begin
      ws = 0;
      xs = 0;
      for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
        ws += mdl_w[c][t];
        xs += mdl_noisy[c][t];
      end
      corr  = ws / clms_pkg::CHANNELS - longint'(mdl_desired[t]);
      xmean = xs / clms_pkg::CHANNELS;
      for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
        delta = (mu_y * (xmean - longint'(mdl_noisy[c][t]))) >>> 12;
        nw = longint'(mdl_w[c][t]) + delta - corr;
        mdl_w[c][t] = 32'(clip(nw, -64'sd2147483648, 64'sd2147483647));
      end
    end
    for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
      for (int t = clms_pkg::TAP_COUNT - 1; t > 0; t--) begin
        mdl_noisy[c][t] = mdl_noisy[c][t-1];
        mdl_clean[c][t] = mdl_clean[c][t-1];
      end
      m = wd.mic[c];
      n = wd.noise[c];
      mdl_clean[c][0] = wd.mic[c];
      mdl_noisy[c][0] = 16'(clip(m + n, -32768, 32767));
    end
    z = array_output(1'b1);
    r.adapt = 32'(y);
    r.clean = 32'(z);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one word per call, optional random gap first
  // ---------------------------------------------------------------------
  task automatic send_word(beam_word_t wd);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= wd.op;
    in_tap_index     <= wd.tap;
    in_desired_value <= wd.desired;
    for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
      in_mic[c]   <= wd.mic[c];
      in_noise[c] <= wd.noise[c];
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(beamform(wd));
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beam_word_t sample_word(logic signed [15:0] mv, logic signed [15:0] nv);
    beam_word_t wd;
    wd.op = OP_SAMPLE;
    wd.tap = 6'($urandom);
    wd.desired = 32'($urandom);
    for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
      wd.mic[c] = mv;
      wd.noise[c] = nv;
    end
    return wd;
  endfunction

  function automatic beam_word_t load_word(logic [5:0] tap, logic signed [31:0] dv);
    beam_word_t wd;
    wd = sample_word(16'($urandom), 16'($urandom));
    wd.op = OP_LOAD;
    wd.tap = tap;
    wd.desired = dv;
    return wd;
  endfunction

  function automatic beam_word_t random_word();
    beam_word_t wd;
    // mostly samples; loads keep re-anchoring the constraint at random taps
    if ($urandom_range(0, 9) == 0) begin
      wd = load_word(6'($urandom), ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                   : 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000);
    end else begin
      wd = sample_word(16'sd0, 16'sd0);
      for (int c = 0; c < clms_pkg::CHANNELS; c++) begin
        wd.mic[c] = rand_sample();
        wd.noise[c] = rand_sample();
      end
    end
    return wd;
  endfunction

  // Step register is only touched once every result is back.
  task automatic write_step(logic [47:0] mu);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_step_size <= mu;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_step = mu;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_load_extremes();
    // desired taps at both ends of the tap range and the value range
    send_word(load_word(6'd0, 32'sh7fffffff));
    send_word(load_word(6'd63, 32'sh80000000));
    send_word(load_word(6'd1, -32'sd3));           // truncation toward zero
    send_word(load_word(6'd2, 32'sh1000_0000));    // unity gain
    send_word(load_word(6'd62, 32'sd0));
  endtask

  task automatic test_sample_extremes();
    send_word(sample_word(16'sh7fff, 16'sh7fff));  // noisy saturates high
    send_word(sample_word(16'sh8000, 16'sh8000));  // noisy saturates low
    send_word(sample_word(16'sh7fff, 16'sh8000));
    send_word(sample_word(16'sd0, 16'sd0));
    send_word(sample_word(-16'sd1, 16'sd1));
    for (int i = 0; i < 6; i++) send_word(random_word());
  endtask

  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++) send_word(random_word());
  endtask

  // ---------------------------------------------------------------------
  // Receiver stall generator
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      stall_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    beam_result_t ex;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word adapt=%0d clean=%0d", out_adapt_output,
               out_clean_output);
        fail_count++;
      end else begin
        ex = pending_results.pop_front();
        if (out_adapt_output !== ex.adapt) begin
          $error("adapt_output expected %0d got %0d", ex.adapt, out_adapt_output);
          fail_count++;
        end
        if (out_clean_output !== ex.clean) begin
          $error("clean_output expected %0d got %0d", ex.clean, out_clean_output);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles in which no word moves on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_load_extremes();
    test_sample_extremes();
    write_step(48'hffff_ffff_ffff);           // largest step
    test_sample_extremes();
    write_step(48'd0);                        // frozen adaptation
    test_random_stream(60);
    write_step(48'($urandom) | (48'($urandom_range(0, 255)) << 32));
    test_backpressure();
    test_random_stream(200);
    write_step(48'd5629);
    test_random_stream(200);
    // last stretch: no idling on either side
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_stream(80);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
